/* hdl/akd_pkg.sv */
// akd_pkg: constants and helper function for the annex-b keyframe detector
// no dependencies; imported by annexb_keyframe_detector
`default_nettype none

package akd_pkg;

	localparam logic [7:0] H264_TYPE_MASK  = 8'h1F;
	localparam logic [4:0] H264_IDR_TYPE   = 5'd5;
	localparam logic [7:0] H265_TYPE_MASK  = 8'h3F;
	localparam logic [5:0] H265_IRAP_FIRST = 6'd16;
	localparam logic [5:0] H265_IRAP_LAST  = 6'd23;

	localparam logic [7:0] BYTE_ZERO       = 8'h00;
	localparam logic [7:0] BYTE_ONE        = 8'h01;
	localparam logic [1:0] ZERO_RUN_MAX    = 2'd2;

	typedef logic [1:0] zero_run_t;

	// classify a nal header byte under the selected codec rules
	function automatic logic header_is_key(input logic [7:0] hdr, input logic is_h265);
		logic [7:0] t264;
		logic [7:0] t265;
		logic       key;
		t264 = hdr & H264_TYPE_MASK;
		t265 = (hdr >> 1) & H265_TYPE_MASK;
		if (is_h265) begin
			key = (t265[5:0] >= H265_IRAP_FIRST) && (t265[5:0] <= H265_IRAP_LAST);
		end else begin
			key = (t264[4:0] == H264_IDR_TYPE);
		end
		return key;
	endfunction

endpackage

`default_nettype wire

/* hdl/annexb_keyframe_detector.sv */
// annexb_keyframe_detector: scans packet bytes for annex-b start codes and
// reports per packet whether an idr (h.264) or irap (h.265) nal unit was seen
// depends on akd_pkg
//
// Usage: bytes of one packet enter on the input channel (in_valid / in_stall,
// data_byte, last_byte), one byte per transaction. Every byte is registered,
// then classified in the following cycle against the start-code tracker.
// Only the byte marked last yields a transaction on the output channel
// (out_valid / out_stall, key_flag), written into the result register at the
// end of the cycle in which it is classified and leaves the input register.
// Throughput is one byte per cycle while the input register is not stalled;
// the limit is the update of the zero-run / header / keyframe state between
// input and result register. When the receiver stalls, the result holds in
// the output register; bytes that produce no result keep flowing, and a
// second last byte waits in the input register, which then stalls the sender.
// codec_is_h265 is written through cfg_we / cfg_wdata while no packet is in
// flight; the user is bound to this, the block itself does not enforce it.
// Reset clears all packet state, both valid flags and selects h.264.
`default_nettype none

module annexb_keyframe_detector
	import akd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic       key_flag
);

	logic       codec_is_h265_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	zero_run_t  zero_run_q;
	logic       expect_header_q;
	logic       keyframe_seen_q;
	logic       out_valid_q;
	logic       key_flag_q;

	logic       s1_move;
	logic       s1_fire;
	logic       in_fire;
	logic       key_now;
	logic       kf_next;
	zero_run_t  zero_run_next;
	logic       expect_next;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_is_h265_q <= 1'b0;
		end else if (cfg_we) begin
			codec_is_h265_q <= cfg_wdata;
		end
	end

	// stage 1 leaves unless it carries a result that cannot be placed
	assign s1_move  = !(last_s1 && out_valid_q && out_stall);
	assign s1_fire  = valid_s1 && s1_move;
	assign in_stall = valid_s1 && !s1_move;
	assign in_fire  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// start code tracking and header classification
	always_comb begin
		key_now       = 1'b0;
		zero_run_next = zero_run_q;
		expect_next   = expect_header_q;
		if (expect_header_q) begin
			key_now       = header_is_key(data_s1, codec_is_h265_q);
			expect_next   = 1'b0;
			zero_run_next = '0;
		end else if (data_s1 == BYTE_ZERO) begin
			if (zero_run_q < ZERO_RUN_MAX) begin
				zero_run_next = zero_run_q + 2'd1;
			end
		end else begin
			if ((data_s1 == BYTE_ONE) && (zero_run_q >= ZERO_RUN_MAX)) begin
				expect_next = 1'b1;
			end
			zero_run_next = '0;
		end
		kf_next = keyframe_seen_q | key_now;
	end

	// packet state, cleared on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q      <= '0;
			expect_header_q <= 1'b0;
			keyframe_seen_q <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				zero_run_q      <= '0;
				expect_header_q <= 1'b0;
				keyframe_seen_q <= 1'b0;
			end else begin
				zero_run_q      <= zero_run_next;
				expect_header_q <= expect_next;
				keyframe_seen_q <= kf_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			key_flag_q <= kf_next;
		end
	end

	assign out_valid = out_valid_q;
	assign key_flag  = key_flag_q;

endmodule

`default_nettype wire
